// File: rtl/sidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_pkg
// Types, constants and width helpers for the signed-integer-to-decimal block.
// ----------------------------------------------------------------------------
package sidc_pkg;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam int unsigned CharWidth = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } sidc_state_e;

  typedef struct packed {
    logic clear;
    logic conv;
    logic shift;
  } sidc_ctrl_t;

  // decimal digits of the largest magnitude, 2^(w-1)
  function automatic int num_digits(input int w);
    logic [64:0] m;
    int          n;
    m = 65'd1 << (w - 1);
    n = 0;
    do begin
      m = m / 10;
      n = n + 1;
    end while (m != '0);
    return n;
  endfunction

endpackage

// File: rtl/sidc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_cell
// One BCD digit: shift-and-add-3 step during conversion, digit move on output.
// ----------------------------------------------------------------------------
module sidc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sidc_pkg::sidc_ctrl_t ctrl_i,
  input  logic                 bit_i,
  input  logic [3:0]           digit_i,
  output logic                 carry_o,
  output logic [3:0]           digit_o
);
  import sidc_pkg::*;

  logic [3:0] digit_q, digit_d, adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// File: rtl/sidc_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_chain
// Row of BCD digit cells, least significant cell first.
// ----------------------------------------------------------------------------
module sidc_chain #(
  parameter int NumDigits = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sidc_pkg::sidc_ctrl_t ctrl_i,
  input  logic                 bit_i,
  output logic [3:0]           top_digit_o
);
  import sidc_pkg::*;

  logic [NumDigits-1:0] carry;
  logic [3:0]           digit [NumDigits];

  assign carry[0] = bit_i;

  for (genvar k = 0; k < NumDigits; k++) begin : g_cell
    if (k == 0) begin : g_first
      if (NumDigits > 1) begin : g_link
        sidc_cell u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .ctrl_i (ctrl_i),
          .bit_i  (carry[0]),
          .digit_i(4'd0),
          .carry_o(carry[1]),
          .digit_o(digit[0])
        );
      end else begin : g_only
        sidc_cell u_cell (
          .clk_i  (clk_i),
          .rst_ni (rst_ni),
          .ctrl_i (ctrl_i),
          .bit_i  (carry[0]),
          .digit_i(4'd0),
          .carry_o(),
          .digit_o(digit[0])
        );
      end
    end else if (k == NumDigits - 1) begin : g_last
      sidc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl_i),
        .bit_i  (carry[k]),
        .digit_i(digit[k-1]),
        .carry_o(),
        .digit_o(digit[k])
      );
    end else begin : g_mid
      sidc_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl_i),
        .bit_i  (carry[k]),
        .digit_i(digit[k-1]),
        .carry_o(carry[k+1]),
        .digit_o(digit[k])
      );
    end
  end

  assign top_digit_o = digit[NumDigits-1];

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer in, decimal ASCII text out, one character per item.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                      | tlast
//  s_axis   | in  | value (VALUE_WIDTH, signed) | -
//  m_axis   | out | character (8)              | last character of a number
//
//  An item's time grows with VALUE_WIDTH and with N, the digit count of
//  2^(VALUE_WIDTH-1); a minus sign adds one more character, and the item
//  also waits for as long as m_axis stalls.
//  The bit-serial shift-and-add-3 pass through the digit cell row sets the
//  conversion time, one input bit per cycle; leading zeros drop one per cycle.
//  Reset clears the state machine; a stalled m_axis holds its character.
//  s_axis is ready only between numbers.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [VALUE_WIDTH-1:0] value, zero fill above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] character
  output logic [7:0]                m_axis_tdata,
  output logic                      m_axis_tlast
);
  import sidc_pkg::*;

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int BitCntW   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int RemW      = $clog2(NumDigits + 1);

  sidc_state_e               state_q, state_d;
  logic [VALUE_WIDTH-1:0]    mag_q, mag_d;
  logic [BitCntW-1:0]        bit_cnt_q, bit_cnt_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic                      neg_q, neg_d;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                      in_fire, out_fire;
  logic [3:0]                top_digit;
  sidc_ctrl_t                ctrl;

  assign value    = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CONV;
      ST_CONV:  if (bit_cnt_q == '0) state_d = ST_SKIP;
      ST_SKIP: begin
        if (!(top_digit == 4'd0 && rem_q > RemW'(1))) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN:  if (out_fire) state_d = ST_DIGIT;
      ST_DIGIT: if (out_fire && rem_q == RemW'(1)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    m_axis_tdata  = CharZero + {4'd0, top_digit};
    m_axis_tlast  = 1'b0;
    ctrl          = '0;
    mag_d         = mag_q;
    bit_cnt_d     = bit_cnt_q;
    rem_d         = rem_q;
    neg_d         = neg_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          ctrl.clear = 1'b1;
          neg_d      = value[VALUE_WIDTH-1];
          mag_d      = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
          bit_cnt_d  = BitCntW'(VALUE_WIDTH - 1);
          rem_d      = RemW'(NumDigits);
        end
      end
      ST_CONV: begin
        ctrl.conv = 1'b1;
        mag_d     = mag_q << 1;
        bit_cnt_d = bit_cnt_q - 1'b1;
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && rem_q > RemW'(1)) begin
          ctrl.shift = 1'b1;
          rem_d      = rem_q - 1'b1;
        end
      end
      ST_SIGN: begin
        m_axis_tvalid = 1'b1;
        m_axis_tdata  = CharMinus;
      end
      ST_DIGIT: begin
        m_axis_tvalid = 1'b1;
        m_axis_tlast  = (rem_q == RemW'(1));
        if (out_fire) begin
          ctrl.shift = 1'b1;
          rem_d      = rem_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bit_cnt_q <= '0;
      rem_q     <= '0;
      neg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
      rem_q     <= rem_d;
      neg_q     <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

  sidc_chain #(
    .NumDigits(NumDigits)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .bit_i      (mag_q[VALUE_WIDTH-1]),
    .top_digit_o(top_digit)
  );

endmodule

// File: rtl/sidc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidc_checker
// Port-level checks for signed_int_to_decimal_ascii, bound to the top level.
// ----------------------------------------------------------------------------
module sidc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import sidc_pkg::*;

  // hold a stalled character
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a character is pending");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("output or ready right after an accepted item");

  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata >= CharZero
      && m_axis_tdata <= CharZero + 8'd9)
    else $error("last character is not a digit");

  a_minus_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata == CharMinus
      |=> !s_axis_tready)
    else $error("number ended on a minus sign");

endmodule

bind signed_int_to_decimal_ascii sidc_checker u_sidc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
